/* rtl/vbi_pkg.sv */
package vbi_pkg;

    // Payload store depth and its address width.
    localparam int PAYLOAD_BYTES = 42;
    localparam int ADDR_W        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    // Datapath widths of the boundary unit.
    localparam int FS_W   = 25;   // sampling rate register
    localparam int ELEM_W = 9;    // element number, up to 360
    localparam int BND_W  = 11;   // boundary in samples, at most 1744
    localparam int PROD_W = FS_W + ELEM_W;
    localparam int REM_W  = 23;   // divider remainder, below the largest divisor
    localparam int STEP_W = $clog2(PROD_W);

    localparam logic [FS_W-1:0] FS_RESET = 25'd13500000;

    // Input item kinds.
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Services.
    localparam logic [1:0] SVC_CC   = 2'd0;
    localparam logic [1:0] SVC_WSS  = 2'd1;
    localparam logic [1:0] SVC_TT   = 2'd2;
    localparam logic [1:0] SVC_NONE = 2'd3;

    // Symbol rates as divisors of n * fs. Teletext divides fs by ten first.
    localparam logic [REM_W-1:0] CC_DIV      = 23'd1000000;
    localparam logic [REM_W-1:0] WSS_DIV     = 23'd5000000;
    localparam logic [REM_W-1:0] TT_DIV      = 23'(6937500 / 10);
    localparam logic [4:0]       TT_PRESCALE = 5'd10;

    localparam logic [ELEM_W-1:0] CC_ELEMS  = 9'd52;
    localparam logic [ELEM_W-1:0] WSS_ELEMS = 9'd137;
    localparam logic [ELEM_W-1:0] TT_ELEMS  = 9'd360;

    // Fixed waveform patterns.
    localparam logic [28:0] WSS_RUN_IN   = 29'h1f1c71c7;
    localparam logic [23:0] WSS_START    = 24'h1e3c1f;
    localparam logic [5:0]  WSS_ONE_PAT  = 6'h38;
    localparam logic [5:0]  WSS_ZERO_PAT = 6'h07;
    localparam logic [7:0]  TT_CLOCK_RUN = 8'h55;
    localparam logic [7:0]  TT_FRAMING   = 8'h27;

    localparam logic [7:0] ONE_LEVEL  = 8'hc0;
    localparam logic [7:0] ZERO_LEVEL = 8'h10;

    // Request to and response from the boundary unit.
    typedef struct packed {
        logic              start;
        logic [1:0]        svc;
        logic [ELEM_W-1:0] n;
        logic [FS_W-1:0]   fs;
    } bnd_req_t;

    typedef struct packed {
        logic             done;
        logic [BND_W-1:0] quo;
    } bnd_rsp_t;

endpackage

/* rtl/vbi_bnd.sv */
// Serial boundary unit: floor(n * fs / rate), with fs first divided by ten for
// teletext. Pre-divide, multiply and divide each retire one bit per cycle.
module vbi_bnd (
    input  logic              aclk,
    input  logic              aresetn,
    input  vbi_pkg::bnd_req_t req,
    output vbi_pkg::bnd_rsp_t rsp
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_PRE  = 4'b0010,
        B_MUL  = 4'b0100,
        B_DIV  = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic    done_reg, done_next;
    logic [vbi_pkg::STEP_W-1:0] step_reg, step_next;

    logic [1:0]                 svc_reg;
    logic [vbi_pkg::ELEM_W-1:0] n_reg;
    logic [vbi_pkg::FS_W-1:0]   f_reg;
    logic [3:0]                 pre_rem_reg;
    logic [vbi_pkg::PROD_W-1:0] prod_reg;
    logic [vbi_pkg::REM_W-1:0]  rem_reg;
    logic [vbi_pkg::BND_W-1:0]  quo_reg;

    logic [vbi_pkg::REM_W-1:0] divisor;
    logic [4:0]                pre_trial;
    logic                      pre_ge;
    logic [vbi_pkg::PROD_W-1:0] prod_add;
    logic [vbi_pkg::REM_W:0]   div_trial;
    logic                      div_ge;

    always_comb begin
        case (svc_reg)
            vbi_pkg::SVC_CC:  divisor = vbi_pkg::CC_DIV;
            vbi_pkg::SVC_WSS: divisor = vbi_pkg::WSS_DIV;
            default:          divisor = vbi_pkg::TT_DIV;
        endcase
    end

    assign pre_trial = {pre_rem_reg, f_reg[vbi_pkg::FS_W-1]};
    assign pre_ge    = (pre_trial >= vbi_pkg::TT_PRESCALE);
    assign prod_add  = n_reg[vbi_pkg::ELEM_W-1] ? vbi_pkg::PROD_W'(f_reg) : '0;
    assign div_trial = {rem_reg, prod_reg[vbi_pkg::PROD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, divisor});

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (req.start) begin
                    if (req.svc == vbi_pkg::SVC_TT) begin
                        state_next = B_PRE;
                        step_next  = vbi_pkg::STEP_W'(vbi_pkg::FS_W - 1);
                    end else begin
                        state_next = B_MUL;
                        step_next  = vbi_pkg::STEP_W'(vbi_pkg::ELEM_W - 1);
                    end
                end
            end
            B_PRE: begin
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = B_MUL;
                    step_next  = vbi_pkg::STEP_W'(vbi_pkg::ELEM_W - 1);
                end
            end
            B_MUL: begin
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = B_DIV;
                    step_next  = vbi_pkg::STEP_W'(vbi_pkg::PROD_W - 1);
                end
            end
            B_DIV: begin
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = B_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (req.start) begin
                    svc_reg     <= req.svc;
                    n_reg       <= req.n;
                    f_reg       <= req.fs;
                    pre_rem_reg <= '0;
                    prod_reg    <= '0;
                end
            end
            B_PRE: begin
                // Restoring division by ten; the quotient replaces fs in place.
                pre_rem_reg <= pre_ge ? 4'(pre_trial - vbi_pkg::TT_PRESCALE) : pre_trial[3:0];
                f_reg       <= {f_reg[vbi_pkg::FS_W-2:0], pre_ge};
            end
            B_MUL: begin
                prod_reg <= {prod_reg[vbi_pkg::PROD_W-2:0], 1'b0} + prod_add;
                n_reg    <= {n_reg[vbi_pkg::ELEM_W-2:0], 1'b0};
                rem_reg  <= '0;
            end
            B_DIV: begin
                // The quotient never exceeds the boundary width, so the upper
                // quotient bits that fall off the register are all zero.
                rem_reg  <= div_ge ? vbi_pkg::REM_W'(div_trial - {1'b0, divisor})
                                   : div_trial[vbi_pkg::REM_W-1:0];
                quo_reg  <= {quo_reg[vbi_pkg::BND_W-2:0], div_ge};
                prod_reg <= {prod_reg[vbi_pkg::PROD_W-2:0], 1'b0};
            end
            default: ;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* rtl/vbi_raw_line_waveform_generator_top.sv */
// Raw VBI line generator for closed caption, WSS and teletext. Load words
// fill the 42-byte payload store and start words select the service;
// neither leaves the idle state. A sample tick word returns one result
// word; on an idle line it goes straight to the output register. On an
// active line every element boundary is worked out by a serial unit (9
// multiply steps, 34 divide steps, plus 25 divide-by-ten steps for
// teletext). A tick evaluates the current element boundary, one more for
// each element it skips, and the final boundary for the last-sample flag,
// then passes through the payload read and the output register; no new
// word is taken until the result word is loaded. The sampling rate port is
// always ready and is meant to be written between words.
module vbi_raw_line_waveform_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [1:0]  s_service,
    input  logic [5:0]  s_byte_index,
    input  logic [7:0]  s_byte_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_sample_value,
    output logic        m_sample_valid,
    output logic        m_last_sample,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [24:0] cfg_sampling_rate
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_RD   = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // Where the bit of one element comes from.
    typedef struct packed {
        logic       from_byte;
        logic       fixed_bit;
        logic       parity;
        logic       wss;
        logic       pat_one;
        logic       pat_zero;
        logic [5:0] addr;
        logic [2:0] sel;
    } bit_src_t;

    state_t state_reg, state_next;
    logic [vbi_pkg::FS_W-1:0]   fs_reg;
    logic [1:0]                 svc_reg, svc_next;
    logic                       active_reg, active_next;
    logic [vbi_pkg::BND_W-1:0]  count_reg, count_next;
    logic [vbi_pkg::ELEM_W-1:0] elem_reg, elem_next;
    logic                       calc_last_reg, calc_last_next;
    logic                       last_reg, last_next;
    logic                       res_zero_reg, res_zero_next;
    logic                       m_valid_reg, m_valid_next;
    logic [7:0]                 m_value_reg;
    logic                       m_svalid_reg;
    logic                       m_last_reg;

    logic [7:0] mem [vbi_pkg::PAYLOAD_BYTES];
    logic [7:0] rd_data_reg;

    vbi_pkg::bnd_req_t bnd_req;
    vbi_pkg::bnd_rsp_t bnd_rsp;

    logic                       s_accept;
    logic                       out_load;
    logic [vbi_pkg::ELEM_W-1:0] total;
    logic [vbi_pkg::ELEM_W-1:0] elem_inc;
    bit_src_t                   src;
    logic                       data_bit;
    logic                       out_bit;

    function automatic logic [vbi_pkg::ELEM_W-1:0] elem_total(input logic [1:0] svc);
        logic [vbi_pkg::ELEM_W-1:0] t;
        case (svc)
            vbi_pkg::SVC_CC:  t = vbi_pkg::CC_ELEMS;
            vbi_pkg::SVC_WSS: t = vbi_pkg::WSS_ELEMS;
            default:          t = vbi_pkg::TT_ELEMS;
        endcase
        return t;
    endfunction

    function automatic bit_src_t decode_bit(input logic [1:0] svc,
                                            input logic [vbi_pkg::ELEM_W-1:0] e);
        bit_src_t   d;
        logic [4:0] k;
        logic [6:0] kw;
        logic [12:0] prod;
        logic [3:0] j;
        logic [2:0] pos;
        logic [2:0] pidx;
        logic [5:0] t;
        logic [5:0] tidx;
        d    = '0;
        k    = '0;
        kw   = 7'(e - 9'd53);
        // k / 6 for k below 84, by reciprocal multiplication.
        prod = 13'(kw) * 13'd43;
        j    = prod[11:8];
        pos  = 3'(kw - 7'(7'(j) * 7'd6));
        pidx = 3'd5 - pos;
        t    = e[8:3];
        tidx = t - 6'd3;
        unique case (svc)
            vbi_pkg::SVC_CC: begin
                if (e < 9'd14) begin
                    d.fixed_bit = e[0];
                end else if (e < 9'd18) begin
                    d.fixed_bit = 1'b0;
                end else if (e < 9'd20) begin
                    d.fixed_bit = 1'b1;
                end else begin
                    if (e < 9'd36) begin
                        k      = 5'(e - 9'd20);
                        d.addr = 6'd0;
                    end else begin
                        k      = {1'b0, 4'(e - 9'd36)};
                        d.addr = 6'd1;
                    end
                    d.from_byte = 1'b1;
                    if (k < 5'd14) begin
                        d.sel = k[3:1];
                    end else begin
                        d.parity = 1'b1;
                    end
                end
            end
            vbi_pkg::SVC_WSS: begin
                if (e < 9'd29) begin
                    d.fixed_bit = vbi_pkg::WSS_RUN_IN[5'd28 - e[4:0]];
                end else if (e < 9'd53) begin
                    d.fixed_bit = vbi_pkg::WSS_START[5'(9'd52 - e)];
                end else begin
                    d.from_byte = 1'b1;
                    d.wss       = 1'b1;
                    d.addr      = (j >= 4'd8) ? 6'd1 : 6'd0;
                    d.sel       = j[2:0];
                    d.pat_one   = vbi_pkg::WSS_ONE_PAT[pidx];
                    d.pat_zero  = vbi_pkg::WSS_ZERO_PAT[pidx];
                end
            end
            vbi_pkg::SVC_TT: begin
                if (t < 6'd2) begin
                    d.fixed_bit = vbi_pkg::TT_CLOCK_RUN[e[2:0]];
                end else if (t == 6'd2) begin
                    d.fixed_bit = vbi_pkg::TT_FRAMING[e[2:0]];
                end else if (tidx < 6'(vbi_pkg::PAYLOAD_BYTES)) begin
                    d.from_byte = 1'b1;
                    d.addr      = tidx;
                    d.sel       = e[2:0];
                end else begin
                    d.fixed_bit = 1'b0;
                end
            end
            default: d.fixed_bit = 1'b0;
        endcase
        return d;
    endfunction

    vbi_bnd u_bnd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bnd_req),
        .rsp     (bnd_rsp)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign total     = elem_total(svc_reg);
    assign elem_inc  = elem_reg + 1'b1;
    assign out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign src      = decode_bit(svc_reg, elem_reg);
    assign data_bit = src.parity ? ~^rd_data_reg[6:0] : rd_data_reg[src.sel];
    always_comb begin
        if (!src.from_byte) begin
            out_bit = src.fixed_bit;
        end else if (src.wss) begin
            out_bit = data_bit ? src.pat_one : src.pat_zero;
        end else begin
            out_bit = data_bit;
        end
    end

    always_comb begin
        state_next     = state_reg;
        svc_next       = svc_reg;
        active_next    = active_reg;
        count_next     = count_reg;
        elem_next      = elem_reg;
        calc_last_next = calc_last_reg;
        last_next      = last_reg;
        res_zero_next  = res_zero_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        bnd_req.start  = 1'b0;
        bnd_req.svc    = svc_reg;
        bnd_req.n      = elem_inc;
        bnd_req.fs     = fs_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_kind)
                        vbi_pkg::KIND_TICK: begin
                            if (active_reg) begin
                                bnd_req.start  = 1'b1;
                                calc_last_next = 1'b0;
                                state_next     = ST_CALC;
                            end else begin
                                res_zero_next = 1'b1;
                                state_next    = ST_EMIT;
                            end
                        end
                        vbi_pkg::KIND_START: begin
                            count_next = '0;
                            elem_next  = '0;
                            if (s_service == vbi_pkg::SVC_NONE) begin
                                active_next = 1'b0;
                            end else begin
                                svc_next    = s_service;
                                active_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CALC: begin
                if (bnd_rsp.done) begin
                    if (!calc_last_reg) begin
                        if (count_reg >= bnd_rsp.quo) begin
                            // The current element covers no more samples.
                            elem_next = elem_inc;
                            if (elem_inc == total) begin
                                active_next   = 1'b0;
                                res_zero_next = 1'b1;
                                state_next    = ST_EMIT;
                            end else begin
                                bnd_req.start = 1'b1;
                                bnd_req.n     = elem_reg + 9'd2;
                            end
                        end else begin
                            calc_last_next = 1'b1;
                            bnd_req.start  = 1'b1;
                            bnd_req.n      = total;
                        end
                    end else begin
                        last_next     = ({1'b0, count_reg} + 12'd1) == {1'b0, bnd_rsp.quo};
                        res_zero_next = 1'b0;
                        state_next    = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (!res_zero_reg) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fs_reg        <= vbi_pkg::FS_RESET;
            svc_reg       <= vbi_pkg::SVC_CC;
            active_reg    <= 1'b0;
            count_reg     <= '0;
            elem_reg      <= '0;
            calc_last_reg <= 1'b0;
            last_reg      <= 1'b0;
            res_zero_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            svc_reg       <= svc_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            elem_reg      <= elem_next;
            calc_last_reg <= calc_last_next;
            last_reg      <= last_next;
            res_zero_reg  <= res_zero_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                fs_reg <= cfg_sampling_rate;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg  <= res_zero_reg ? 8'd0
                          : (out_bit ? vbi_pkg::ONE_LEVEL : vbi_pkg::ZERO_LEVEL);
            m_svalid_reg <= !res_zero_reg;
            m_last_reg   <= !res_zero_reg && last_reg;
        end
    end

    // Payload store: one write port for load words, one registered read port.
    always_ff @(posedge aclk) begin
        if (s_accept && (s_kind == vbi_pkg::KIND_LOAD)
                && (s_byte_index < 6'(vbi_pkg::PAYLOAD_BYTES))) begin
            mem[s_byte_index[vbi_pkg::ADDR_W-1:0]] <= s_byte_value;
        end
        if (state_reg == ST_RD) begin
            rd_data_reg <= mem[src.addr[vbi_pkg::ADDR_W-1:0]];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_value_reg;
    assign m_sample_valid = m_svalid_reg;
    assign m_last_sample  = m_last_reg;

endmodule
